### sv/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### sv/rdid_pkg.sv
// Types and constants of the RLE / DPCM image decoder.
// No dependencies; used by the front end, queue, back end and top level.
`default_nettype none

package rdid_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int LS_AW = $clog2(MAX_WIDTH);
  localparam int COL_W = 10;
  localparam int ROW_W = 16;
  localparam int PIX_W = 16;
  localparam int WREG_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CTRL_RUN = 8'h80;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_TRUNC = 2'd1;
  localparam logic [1:0] STATUS_FORMAT = 2'd2;

  typedef enum logic [1:0] {
    KIND_CTRL = 2'd0,
    KIND_LIT  = 2'd1,
    KIND_RUN  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic             pixel_valid;
    logic [PIX_W-1:0] pixel_value;
    logic [COL_W-1:0] pixel_column;
    logic [ROW_W-1:0] pixel_row;
    logic             row_done;
    logic             frame_done;
    logic [1:0]       frame_status;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic [7:0] byte_val;
    cmd_kind_e  kind;
    logic [7:0] count;
    logic       stream_end;
    logic       lit_open;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic idle;
    logic image_complete;
  } be_stat_t;

endpackage

`default_nettype wire

### sv/rdid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rdid_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/rdid_fifo.sv
// Command queue between the parser front end and the pixel back end.
// Depends on rdid_pkg.
`default_nettype none

module rdid_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rdid_pkg::cmd_t  push_cmd_i,
  input  wire logic            pop_i,
  output rdid_pkg::cmd_t       head_o,
  output rdid_pkg::q_stat_t    stat_o
);

  localparam int PW = $clog2(rdid_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(rdid_pkg::FIFO_DEPTH + 1);

  rdid_pkg::cmd_t mem_q [rdid_pkg::FIFO_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;

  assign head_o = mem_q[rptr_q];
  assign stat_o.full = (cnt_q == CW'(rdid_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(rdid_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(rdid_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### sv/rdid_front.sv
// Front end: accepts compressed bytes, tracks the RLE control state and
// queues one command per byte. Depends on rdid_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rdid_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rdid_pkg::in_t     in_data_i,
  input  wire rdid_pkg::q_stat_t q_stat_i,
  input  wire rdid_pkg::be_stat_t be_stat_i,
  output logic                   push_o,
  output rdid_pkg::cmd_t         cmd_o
);

  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] rem_q, rem_d;
  logic       drained;

  // control bytes need the true completion state, so wait for the back end
  assign drained = q_stat_i.empty && be_stat_i.idle;
  assign in_stall_o = q_stat_i.full || ((phase_q == PH_CTRL) && !drained);
  assign push_o = in_valid_i && !in_stall_o;

  always_comb begin
    phase_d = phase_q;
    rem_d = rem_q;
    cmd_o.byte_val = in_data_i.in_byte;
    cmd_o.kind = rdid_pkg::KIND_CTRL;
    cmd_o.count = rem_q;
    cmd_o.stream_end = in_data_i.stream_end;
    case (phase_q)
      PH_CTRL: begin
        if (!be_stat_i.image_complete) begin
          if (in_data_i.in_byte < rdid_pkg::CTRL_RUN) begin
            rem_d = in_data_i.in_byte + 8'd1;
            phase_d = PH_LIT;
          end else begin
            rem_d = in_data_i.in_byte - (rdid_pkg::CTRL_RUN - 8'd1);
            phase_d = PH_RUN;
          end
        end
      end
      PH_LIT: begin
        cmd_o.kind = rdid_pkg::KIND_LIT;
        rem_d = rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          phase_d = PH_CTRL;
        end
      end
      PH_RUN: begin
        cmd_o.kind = rdid_pkg::KIND_RUN;
        rem_d = '0;
        phase_d = PH_CTRL;
      end
      default: begin
        phase_d = PH_CTRL;
        rem_d = '0;
      end
    endcase
    cmd_o.lit_open = (phase_d == PH_LIT);
    if (in_data_i.stream_end) begin
      phase_d = PH_CTRL;
      rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CTRL;
      rem_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      rem_q <= rem_d;
    end
  end

  `ASSERT_IMPLIES(a_lit_has_bytes, clk_i, rst_ni, phase_q == PH_LIT, rem_q != '0, "empty literal")
  `ASSERT_IMPLIES(a_push_not_full, clk_i, rst_ni, push_o, !q_stat_i.full, "push into full queue")
  `ASSERT_IMPLIES(a_ctrl_drained, clk_i, rst_ni, push_o && phase_q == PH_CTRL, drained, "early ctrl")
  `ASSERT_ALWAYS(a_phase_legal, clk_i, rst_ni, phase_q != (PH_LIT | PH_RUN), "bad parse phase")

endmodule

`default_nettype wire

### sv/rdid_back.sv
// Back end: executes queued commands, pairs bytes into residuals, rebuilds
// pixels with the line store and drives the result register.
// Depends on rdid_pkg, rdid_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rdid_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [rdid_pkg::WREG_W-1:0]      image_width_i,
  input  wire logic [rdid_pkg::ROW_W-1:0]       image_height_i,
  input  wire rdid_pkg::cmd_t                   head_i,
  input  wire rdid_pkg::q_stat_t                q_stat_i,
  output logic                                  pop_o,
  output rdid_pkg::be_stat_t                    stat_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output rdid_pkg::out_t                        out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FEED = 2'd1;
  localparam logic [1:0] S_PIX  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam int WW = rdid_pkg::WREG_W;
  localparam int RW = rdid_pkg::ROW_W;

  logic [1:0] state_q, state_d;
  rdid_pkg::cmd_t cmd_q, cmd_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] low_q, low_d;
  logic low_held_q, low_held_d;
  logic [rdid_pkg::PIX_W-1:0] hsum_q, hsum_d;
  logic [rdid_pkg::COL_W-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic done_q, done_d;
  logic extra_q, extra_d;
  logic leftover_q, leftover_d;
  logic hold_v_q, hold_v_d;
  rdid_pkg::out_t hold_q, hold_d;
  logic out_v_q, out_v_d;
  rdid_pkg::out_t out_q, out_d;

  logic rd_en, we;
  logic [rdid_pkg::PIX_W-1:0] ls_rdata, pix_val;
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic rdone, last_row, out_free;

  rdid_ram #(
    .WIDTH (rdid_pkg::PIX_W),
    .DEPTH (rdid_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (col_q[rdid_pkg::LS_AW-1:0]),
    .wdata_i (pix_val),
    .re_i    (rd_en),
    .raddr_i (col_q[rdid_pkg::LS_AW-1:0]),
    .rdata_o (ls_rdata)
  );

  always_comb begin
    if (image_width_i == '0) begin
      w_eff = WW'(1);
    end else if (image_width_i > WW'(rdid_pkg::MAX_WIDTH)) begin
      w_eff = WW'(rdid_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width_i;
    end
    h_eff = (image_height_i == '0) ? RW'(1) : image_height_i;
  end

  assign rdone = (WW'(col_q) + WW'(1)) >= w_eff;
  assign last_row = ({1'b0, row_q} + (RW + 1)'(1)) >= {1'b0, h_eff};
  assign out_free = !out_v_q || !out_stall_i;
  assign stat_o.idle = (state_q == S_IDLE);
  assign stat_o.image_complete = done_q;
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  always_comb begin
    logic [rdid_pkg::PIX_W-1:0] res;
    logic [rdid_pkg::PIX_W-1:0] hs;
    logic push_out;
    rdid_pkg::out_t out_new;

    state_d = state_q;
    cmd_d = cmd_q;
    rem_d = rem_q;
    low_d = low_q;
    low_held_d = low_held_q;
    hsum_d = hsum_q;
    col_d = col_q;
    row_d = row_q;
    done_d = done_q;
    extra_d = extra_q;
    leftover_d = leftover_q;
    hold_v_d = hold_v_q;
    hold_d = hold_q;
    pop_o = 1'b0;
    rd_en = 1'b0;
    we = 1'b0;
    push_out = 1'b0;
    out_new = hold_q;
    res = {cmd_q.byte_val, low_q};
    hs = (col_q == '0) ? res : hsum_q + res;
    pix_val = (row_q != '0) ? hs + ls_rdata : hs;

    case (state_q)
      S_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          if (done_q) begin
            extra_d = 1'b1;
            state_d = S_FIN;
          end else if (head_i.kind == rdid_pkg::KIND_LIT) begin
            rem_d = 8'd1;
            state_d = S_FEED;
          end else if (head_i.kind == rdid_pkg::KIND_RUN) begin
            rem_d = head_i.count;
            state_d = S_FEED;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FEED: begin
        if (rem_q == '0) begin
          state_d = S_FIN;
        end else if (done_q) begin
          leftover_d = 1'b1;
          state_d = S_FIN;
        end else if (!low_held_q) begin
          low_d = cmd_q.byte_val;
          low_held_d = 1'b1;
          rem_d = rem_q - 8'd1;
        end else if (!hold_v_q || out_free) begin
          // a newer pixel follows, so the held one is not the last of the beat
          push_out = hold_v_q;
          hold_v_d = 1'b0;
          rd_en = 1'b1;
          rem_d = rem_q - 8'd1;
          state_d = S_PIX;
        end
      end
      S_PIX: begin
        hsum_d = hs;
        we = 1'b1;
        hold_v_d = 1'b1;
        hold_d = '0;
        hold_d.pixel_valid = 1'b1;
        hold_d.pixel_value = pix_val;
        hold_d.pixel_column = col_q;
        hold_d.pixel_row = row_q;
        hold_d.row_done = rdone;
        low_held_d = 1'b0;
        low_d = '0;
        if (rdone) begin
          col_d = '0;
          if (last_row) begin
            done_d = 1'b1;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          col_d = col_q + rdid_pkg::COL_W'(1);
        end
        state_d = S_FEED;
      end
      S_FIN: begin
        if (hold_v_q || cmd_q.stream_end) begin
          if (out_free) begin
            push_out = 1'b1;
            out_new = hold_v_q ? hold_q : '0;
            out_new.last_of_run = 1'b1;
            hold_v_d = 1'b0;
            if (cmd_q.stream_end) begin
              out_new.frame_done = 1'b1;
              if (!done_q || cmd_q.lit_open) begin
                out_new.frame_status = rdid_pkg::STATUS_TRUNC;
              end else if (extra_q || leftover_q) begin
                out_new.frame_status = rdid_pkg::STATUS_FORMAT;
              end else begin
                out_new.frame_status = rdid_pkg::STATUS_OK;
              end
              low_d = '0;
              low_held_d = 1'b0;
              hsum_d = '0;
              col_d = '0;
              row_d = '0;
              done_d = 1'b0;
              extra_d = 1'b0;
              leftover_d = 1'b0;
            end
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push_out) begin
      out_v_d = 1'b1;
      out_d = out_new;
    end else begin
      out_v_d = out_v_q && out_stall_i;
      out_d = out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    hold_q <= hold_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q <= '0;
      low_q <= '0;
      low_held_q <= 1'b0;
      hsum_q <= '0;
      col_q <= '0;
      row_q <= '0;
      done_q <= 1'b0;
      extra_q <= 1'b0;
      leftover_q <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q <= rem_d;
      low_q <= low_d;
      low_held_q <= low_held_d;
      hsum_q <= hsum_d;
      col_q <= col_d;
      row_q <= row_d;
      done_q <= done_d;
      extra_q <= extra_d;
      leftover_q <= leftover_d;
      hold_v_q <= hold_v_d;
      out_v_q <= out_v_d;
    end
  end

  `ASSERT_ALWAYS(a_no_hold_idle, clk_i, rst_ni, !(state_q == S_IDLE && hold_v_q), "pixel held across beats")
  `ASSERT_IMPLIES(a_done_col_zero, clk_i, rst_ni, done_q, col_q == '0, "image complete mid-row")
  `ASSERT_IMPLIES(a_pix_has_low, clk_i, rst_ni, state_q == S_PIX, low_held_q, "pixel without low byte")

endmodule

`default_nettype wire

### sv/rle_dpcm_image_decoder_unit.sv
// Flow: the back end takes a low byte, then for each pixel reads the line
// store, then adds and writes; control bytes wait until the command queue
// and back end have drained.
// Reset: asynchronous, active low; clears parse and frame state and sets the
// image width and height to 1; the line store is not cleared and is valid
// only where written.
`default_nettype none

module rle_dpcm_image_decoder_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire rdid_pkg::in_t                      in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output rdid_pkg::out_t                          out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rdid_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rdid_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic [rdid_pkg::WREG_W-1:0] width_q;
  logic [rdid_pkg::ROW_W-1:0] height_q;

  rdid_pkg::q_stat_t q_stat;
  rdid_pkg::be_stat_t be_stat;
  rdid_pkg::cmd_t push_cmd, head_cmd;
  logic push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= rdid_pkg::WREG_W'(1);
      height_q <= rdid_pkg::ROW_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rdid_pkg::CFG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i[rdid_pkg::WREG_W-1:0];
        end
        rdid_pkg::CFG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i[rdid_pkg::ROW_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  rdid_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .be_stat_i  (be_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rdid_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .stat_o     (q_stat)
  );

  rdid_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .head_i         (head_cmd),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .stat_o         (be_stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

`default_nettype wire
